[rtl/qmn_pkg.sv]
// Types, constants and helper functions shared by the quaternion product blocks.
`timescale 1ns / 1ps
package qmn_pkg;

  localparam int unsigned CW     = 32;
  localparam int unsigned PW     = 64;
  localparam int unsigned SUMW   = 66;
  localparam int unsigned MAGW   = 65;
  localparam int unsigned LENW   = 7;
  localparam int unsigned CHUNKS = 9;
  localparam int unsigned CMW    = 31;
  localparam int unsigned SQW    = 62;
  localparam int unsigned RADW   = 64;
  localparam int unsigned ROOTW  = 32;
  localparam int unsigned SREMW  = 33;
  localparam int unsigned NW     = 33;
  localparam int unsigned QW     = 32;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTRW  = 2;
  localparam int unsigned QCNTW  = 3;
  localparam int unsigned SQ_STEPS  = 32;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned FRONT_STAGES = 6;
  localparam int unsigned BACK_STAGES  = 3 + SQ_STEPS + 2 + DIV_STEPS + 1;
  localparam logic [QW-1:0] ONE_Q130 = QW'(32'h4000_0000);
  localparam logic [CMW-1:0] CMAX = '1;

  // [component][term] base subtraction pattern of the Hamilton product
  localparam logic [3:0][3:0] TERM_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

  typedef struct packed {
    logic [3:0][MAGW-1:0] mag;
    logic [3:0]           neg;
    logic [LENW-1:0]      len;
  } qitem_t;

  typedef struct packed {
    logic [3:0][CMW-1:0] c;
    logic [3:0]          neg;
    logic                zero;
  } qcarry_t;

  function automatic logic [3:0] bitlen8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage

[rtl/quaternion_multiply_normalize_top.sv]
// Top level of the normalized quaternion product block.
//
//  channel | direction | tdata                          | tuser
//  in_     | slave     | a_w,a_x,a_y,a_z,b_w,b_x,b_y,b_z | op
//  out_    | master    | r_w,r_x,r_y,r_z                 | zero_norm
//
//  One item per cycle sustained while out_tready is high. An item passes
//  6 front stages, one queue slot, 70 back stages ending in the output
//  register; most are the 32-step square root and 32-step divider stages.
//  Reset is synchronous and clears all valid bits and the queue.
//  An output stall freezes the back pipeline; the front keeps taking items
//  until the 4-entry queue fills.
`timescale 1ns / 1ps
module quaternion_multiply_normalize_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  logic [0:0]   in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // r_w, r_x, r_y, r_z
  output logic [0:0]   out_tuser   // zero_norm
);

  logic signed [qmn_pkg::CW-1:0] a_v [4];
  logic signed [qmn_pkg::CW-1:0] b_v [4];
  qmn_pkg::qitem_t f_item, q_item;
  logic f_valid, q_full, q_empty, q_pop, q_push;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a_v[k] = in_tdata[k*qmn_pkg::CW +: qmn_pkg::CW];
      b_v[k] = in_tdata[(k+4)*qmn_pkg::CW +: qmn_pkg::CW];
    end
  end

  assign q_push = f_valid && !q_full;

  qmn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser[0]),
    .in_a      (a_v),
    .in_b      (b_v),
    .out_valid (f_valid),
    .out_ready (!q_full),
    .out_item  (f_item)
  );

  qmn_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (f_item),
    .pop     (q_pop),
    .rd_item (q_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  qmn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_zero  (out_tuser[0])
  );

endmodule

[rtl/qmn_front.sv]
// Front pipeline: operand selection, exact products, component sums, magnitudes, bit length.
`timescale 1ns / 1ps
module qmn_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic signed [qmn_pkg::CW-1:0]   in_a [4],
  input  logic signed [qmn_pkg::CW-1:0]   in_b [4],
  output logic                            out_valid,
  input  logic                            out_ready,
  output qmn_pkg::qitem_t                 out_item
);

  logic [qmn_pkg::FRONT_STAGES-1:0] v_r;
  logic en;

  logic                          op_r;
  logic signed [qmn_pkg::CW-1:0] a_r [4];
  logic signed [qmn_pkg::CW-1:0] b_r [4];
  logic signed [qmn_pkg::CW-1:0] l_op [4];
  logic signed [qmn_pkg::CW-1:0] r_op [4];
  logic [3:0][3:0]               tneg;

  logic signed [qmn_pkg::PW-1:0] prod_r [4][4];
  logic [3:0][3:0]               pneg_r;

  logic signed [qmn_pkg::SUMW-1:0] sum_nxt [4];
  logic signed [qmn_pkg::SUMW-1:0] sum_r   [4];

  logic [3:0][qmn_pkg::MAGW-1:0] mag4_r, mag5_r, mag6_r;
  logic [3:0]                    neg4_r, neg5_r, neg6_r;
  logic [qmn_pkg::MAGW-1:0]      orw;
  logic [qmn_pkg::CHUNKS*8-1:0]  orw_pad;
  logic [3:0]                    chlen_r [qmn_pkg::CHUNKS];
  logic [qmn_pkg::LENW-1:0]      len_nxt, len_r;

  assign en        = !v_r[qmn_pkg::FRONT_STAGES-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[qmn_pkg::FRONT_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[qmn_pkg::FRONT_STAGES-2:0], in_valid};
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      l_op[k] = op_r ? b_r[k] : a_r[k];
      r_op[k] = op_r ? a_r[k] : b_r[k];
    end
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        tneg[c][k] = qmn_pkg::TERM_NEG[c][k] ^ (op_r && (c != k));
      end
    end
  end

  always_comb begin
    logic signed [qmn_pkg::SUMW-1:0] t;
    for (int c = 0; c < 4; c++) begin
      sum_nxt[c] = '0;
      for (int k = 0; k < 4; k++) begin
        t = {{(qmn_pkg::SUMW - qmn_pkg::PW){prod_r[c][k][qmn_pkg::PW-1]}}, prod_r[c][k]};
        sum_nxt[c] = pneg_r[c][k] ? sum_nxt[c] - t : sum_nxt[c] + t;
      end
    end
  end

  always_comb begin
    orw = '0;
    for (int c = 0; c < 4; c++) orw = orw | mag4_r[c];
    orw_pad = {{(qmn_pkg::CHUNKS*8 - qmn_pkg::MAGW){1'b0}}, orw};
  end

  always_comb begin
    len_nxt = '0;
    for (int k = 0; k < qmn_pkg::CHUNKS; k++) begin
      if (chlen_r[k] != '0) len_nxt = qmn_pkg::LENW'(8 * k) + qmn_pkg::LENW'(chlen_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r <= in_op;
      for (int k = 0; k < 4; k++) begin
        a_r[k] <= in_a[k];
        b_r[k] <= in_b[k];
      end
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod_r[c][k] <= l_op[k] * r_op[c ^ k];
        end
      end
      pneg_r <= tneg;
      for (int c = 0; c < 4; c++) begin
        sum_r[c]  <= sum_nxt[c];
        neg4_r[c] <= sum_r[c][qmn_pkg::SUMW-1];
        mag4_r[c] <= sum_r[c][qmn_pkg::SUMW-1] ? qmn_pkg::MAGW'(-sum_r[c])
                                               : qmn_pkg::MAGW'(sum_r[c]);
      end
      for (int k = 0; k < qmn_pkg::CHUNKS; k++) begin
        chlen_r[k] <= qmn_pkg::bitlen8(orw_pad[k*8 +: 8]);
      end
      mag5_r <= mag4_r;
      neg5_r <= neg4_r;
      mag6_r <= mag5_r;
      neg6_r <= neg5_r;
      len_r  <= len_nxt;
    end
  end

  assign out_item.mag = mag6_r;
  assign out_item.neg = neg6_r;
  assign out_item.len = len_r;

endmodule

[rtl/qmn_queue.sv]
// Short item queue between the front and back pipelines.
`timescale 1ns / 1ps
module qmn_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  qmn_pkg::qitem_t wr_item,
  input  logic            pop,
  output qmn_pkg::qitem_t rd_item,
  output logic            full,
  output logic            empty
);

  qmn_pkg::qitem_t            mem_r [qmn_pkg::QDEPTH];
  logic [qmn_pkg::QPTRW-1:0]  wp_r, rp_r;
  logic [qmn_pkg::QCNTW-1:0]  cnt_r;

  assign full    = (cnt_r == qmn_pkg::QCNTW'(qmn_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

endmodule

[rtl/qmn_back.sv]
// Back pipeline: scale to 31 bits, sum of squares, square root, per-lane division, output.
`timescale 1ns / 1ps
module qmn_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  qmn_pkg::qitem_t             q_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [4*qmn_pkg::CW-1:0]    out_data,
  output logic                        out_zero
);

  localparam int unsigned NB  = qmn_pkg::BACK_STAGES;
  localparam int unsigned S_SQ0 = 3;
  localparam int unsigned S_RND = S_SQ0 + qmn_pkg::SQ_STEPS;
  localparam int unsigned S_NUM = S_RND + 1;
  localparam int unsigned S_DV0 = S_NUM + 1;

  logic [NB-1:0]    vld_r;
  logic             ben;
  qmn_pkg::qcarry_t cp_r [NB];
  qmn_pkg::qcarry_t cp_nxt;

  logic [qmn_pkg::SQW-1:0]   sq_r [4];
  logic [qmn_pkg::RADW-1:0]  ssum_r;

  logic [qmn_pkg::RADW-1:0]  srad_r  [qmn_pkg::SQ_STEPS];
  logic [qmn_pkg::SREMW-1:0] srem_r  [qmn_pkg::SQ_STEPS];
  logic [qmn_pkg::ROOTW-1:0] sroot_r [qmn_pkg::SQ_STEPS];

  logic [qmn_pkg::NW-1:0]    n_r;
  logic [qmn_pkg::NW-1:0]    dn_r   [qmn_pkg::DIV_STEPS + 1];
  logic [qmn_pkg::NW-1:0]    drem_r [qmn_pkg::DIV_STEPS + 1][4];
  logic [qmn_pkg::QW-1:0]    dlq_r  [qmn_pkg::DIV_STEPS + 1][4];

  logic [3:0][qmn_pkg::CW-1:0] r_nxt;

  assign ben       = !vld_r[NB-1] || out_ready;
  assign q_pop     = ben && !q_empty;
  assign out_valid = vld_r[NB-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ben) begin
      vld_r <= {vld_r[NB-2:0], q_pop};
    end
  end

  always_comb begin
    logic [qmn_pkg::MAGW-1:0] shv;
    logic [qmn_pkg::CW-1:0]   m;
    logic [qmn_pkg::LENW-1:0] sm1;
    cp_nxt.neg  = q_item.neg;
    cp_nxt.zero = (q_item.len == '0);
    sm1 = q_item.len - qmn_pkg::LENW'(32);
    for (int i = 0; i < 4; i++) begin
      shv = q_item.mag[i] >> sm1;
      if (q_item.len > qmn_pkg::LENW'(31)) begin
        m = qmn_pkg::CW'(shv >> 1) + qmn_pkg::CW'(shv[0]);
      end else begin
        m = {1'b0, q_item.mag[i][qmn_pkg::CMW-1:0] << (qmn_pkg::LENW'(31) - q_item.len)};
      end
      cp_nxt.c[i] = m[qmn_pkg::CW-1] ? qmn_pkg::CMAX : m[qmn_pkg::CMW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      cp_r[0] <= cp_nxt;
      for (int i = 1; i < NB; i++) cp_r[i] <= cp_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [qmn_pkg::RADW-1:0] acc;
    if (ben) begin
      acc = '0;
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= cp_r[0].c[i] * cp_r[0].c[i];
        acc = acc + qmn_pkg::RADW'(sq_r[i]);
      end
      ssum_r <= acc;
    end
  end

  for (genvar j = 0; j < qmn_pkg::SQ_STEPS; j++) begin : g_sqrt
    logic [qmn_pkg::RADW-1:0]  rad_in;
    logic [qmn_pkg::SREMW-1:0] rem_in;
    logic [qmn_pkg::ROOTW-1:0] root_in;
    logic [qmn_pkg::SREMW+1:0] remsh, trial;
    logic                      ge;
    if (j == 0) begin : g_first
      assign rad_in  = ssum_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = srad_r[j-1];
      assign rem_in  = srem_r[j-1];
      assign root_in = sroot_r[j-1];
    end
    assign remsh = {rem_in, rad_in[qmn_pkg::RADW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (remsh >= trial);
    always_ff @(posedge clk) begin
      if (ben) begin
        srad_r[j]  <= rad_in << 2;
        srem_r[j]  <= ge ? qmn_pkg::SREMW'(remsh - trial) : qmn_pkg::SREMW'(remsh);
        sroot_r[j] <= {root_in[qmn_pkg::ROOTW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [qmn_pkg::SREMW-1:0] rem_f;
    logic [qmn_pkg::ROOTW-1:0] root_f;
    logic [qmn_pkg::SQW-1:0]   num;
    if (ben) begin
      rem_f  = srem_r[qmn_pkg::SQ_STEPS-1];
      root_f = sroot_r[qmn_pkg::SQ_STEPS-1];
      n_r <= qmn_pkg::NW'(root_f) + qmn_pkg::NW'(rem_f > qmn_pkg::SREMW'(root_f));
      dn_r[0] <= n_r;
      for (int i = 0; i < 4; i++) begin
        num = {cp_r[S_RND].c[i], 30'b0} + qmn_pkg::SQW'(n_r >> 1);
        drem_r[0][i] <= qmn_pkg::NW'(num[qmn_pkg::SQW-1:qmn_pkg::QW]);
        dlq_r[0][i]  <= num[qmn_pkg::QW-1:0];
      end
    end
  end

  for (genvar j = 0; j < qmn_pkg::DIV_STEPS; j++) begin : g_div
    for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [qmn_pkg::NW:0] remsh;
      logic                 ge;
      assign remsh = {drem_r[j][i], dlq_r[j][i][qmn_pkg::QW-1]};
      assign ge    = (remsh >= {1'b0, dn_r[j]});
      always_ff @(posedge clk) begin
        if (ben) begin
          drem_r[j+1][i] <= ge ? qmn_pkg::NW'(remsh - {1'b0, dn_r[j]})
                               : qmn_pkg::NW'(remsh);
          dlq_r[j+1][i]  <= {dlq_r[j][i][qmn_pkg::QW-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (ben) dn_r[j+1] <= dn_r[j];
    end
  end

  always_comb begin
    logic [qmn_pkg::QW-1:0] q;
    for (int i = 0; i < 4; i++) begin
      q = dlq_r[qmn_pkg::DIV_STEPS][i];
      if (q > qmn_pkg::ONE_Q130) q = qmn_pkg::ONE_Q130;
      if (cp_r[NB-2].zero) q = '0;
      r_nxt[i] = cp_r[NB-2].neg[i] ? qmn_pkg::CW'(-q) : qmn_pkg::CW'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      out_data <= r_nxt;
      out_zero <= cp_r[NB-2].zero;
    end
  end

endmodule

[rtl/qmn_checker.sv]
// Port-level checks for the normalized quaternion product block, bound to the top level.
`timescale 1ns / 1ps
module qmn_props (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [255:0] in_tdata,
  input logic [0:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic [0:0]   out_tuser
);

  localparam logic signed [31:0] LIM_HI = 32'sh4000_0000;
  localparam logic signed [31:0] LIM_LO = -32'sh4000_0000;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("zero norm with nonzero components");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      $signed(out_tdata[31:0])   <= LIM_HI && $signed(out_tdata[31:0])   >= LIM_LO &&
      $signed(out_tdata[63:32])  <= LIM_HI && $signed(out_tdata[63:32])  >= LIM_LO &&
      $signed(out_tdata[95:64])  <= LIM_HI && $signed(out_tdata[95:64])  >= LIM_LO &&
      $signed(out_tdata[127:96]) <= LIM_HI && $signed(out_tdata[127:96]) >= LIM_LO)
    else $error("component beyond unit range");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind quaternion_multiply_normalize_top qmn_props u_qmn_props (.*);

[tb/qmn_checker.sv]
// Checker: watches both channels, predicts the normalized quaternion product, compares.
`timescale 1ns / 1ps
module qmn_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [255:0] in_tdata,
  input  logic [0:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic [0:0]   out_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [31:0] r_z;
    logic [31:0] r_y;
    logic [31:0] r_x;
    logic [31:0] r_w;
    logic        zero_norm;
  } unit_quat_t;

  unit_quat_t unit_queue[$];

  function automatic logic [63:0] root_nearest(input logic [63:0] v);
    logic [63:0] r, bit_v, rem;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v = v - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    rem = v;
    if (rem > r) r = r + 1;
    return r;
  endfunction

  function automatic unit_quat_t normalize_product(input logic op, input logic [255:0] d);
    logic signed [63:0] q [8];
    logic signed [63:0] lw, lx, ly, lz, rw, rx, ry, rz;
    logic signed [127:0] comp [4];
    logic [127:0] mag [4];
    logic [63:0] c [4];
    logic [63:0] sum, n, r;
    logic [3:0] neg;
    int maxlen, s;
    unit_quat_t res;
    for (int i = 0; i < 8; i++) q[i] = $signed(d[32*i +: 32]);
    if (!op) begin
      lw = q[0]; lx = q[1]; ly = q[2]; lz = q[3];
      rw = q[4]; rx = q[5]; ry = q[6]; rz = q[7];
    end else begin
      lw = q[4]; lx = q[5]; ly = q[6]; lz = q[7];
      rw = q[0]; rx = -q[1]; ry = -q[2]; rz = -q[3];
    end
    comp[0] = 128'(lw * rw) - 128'(lx * rx) - 128'(ly * ry) - 128'(lz * rz);
    comp[1] = 128'(lw * rx) + 128'(lx * rw) + 128'(ly * rz) - 128'(lz * ry);
    comp[2] = 128'(lw * ry) - 128'(lx * rz) + 128'(ly * rw) + 128'(lz * rx);
    comp[3] = 128'(lw * rz) + 128'(lx * ry) - 128'(ly * rx) + 128'(lz * rw);
    maxlen = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = comp[i][127];
      mag[i] = neg[i] ? -comp[i] : comp[i];
      for (int b = 0; b < 128; b++) if (mag[i][b] && b + 1 > maxlen) maxlen = b + 1;
    end
    res = '0;
    if (maxlen == 0) begin
      res.zero_norm = 1'b1;
      return res;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      if (maxlen > 31) begin
        s = maxlen - 31;
        c[i] = 64'(mag[i] >> s) + 64'(mag[i][s-1]);
      end else begin
        c[i] = 64'(mag[i] << (31 - maxlen));
      end
      if (c[i] > 64'h7FFF_FFFF) c[i] = 64'h7FFF_FFFF;
      sum = sum + c[i] * c[i];
    end
    n = root_nearest(sum);
    for (int i = 0; i < 4; i++) begin
      r = ((c[i] << 30) + (n >> 1)) / n;
      if (r > (64'd1 << 30)) r = 64'd1 << 30;
      if (neg[i]) r = -r;
      case (i)
        0: res.r_w = r[31:0];
        1: res.r_x = r[31:0];
        2: res.r_y = r[31:0];
        default: res.r_z = r[31:0];
      endcase
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    unit_quat_t want, got;
    if (rst_n && in_tvalid && in_tready)
      unit_queue.push_back(normalize_product(in_tuser[0], in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[127:96], out_tdata[95:64], out_tdata[63:32], out_tdata[31:0],
             out_tuser[0]};
      if (unit_queue.size() == 0) begin
        $error("unexpected result item %h", out_tdata);
        fail_count <= fail_count + 1;
      end else begin
        want = unit_queue.pop_front();
        if (got.r_w !== want.r_w) $error("r_w exp %h got %h", want.r_w, got.r_w);
        if (got.r_x !== want.r_x) $error("r_x exp %h got %h", want.r_x, got.r_x);
        if (got.r_y !== want.r_y) $error("r_y exp %h got %h", want.r_y, got.r_y);
        if (got.r_z !== want.r_z) $error("r_z exp %h got %h", want.r_z, got.r_z);
        if (got.zero_norm !== want.zero_norm)
          $error("zero_norm exp %b got %b", want.zero_norm, got.zero_norm);
        if (got !== want) fail_count <= fail_count + 1;
      end
    end
    pending <= unit_queue.size();
  end

endmodule

[tb/tb_top.sv]
// Testbench top: drives quaternion pairs, stalls the result side and gives the verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int RANDOM_ITEMS = 2000;
  localparam int LATENCY = 77;
  localparam int IDLE_LIMIT = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic [0:0]   out_tuser;
  int           fail_count;
  int           pending;
  int           idle_cycles;
  int           out_wait;
  bit           out_steady;

  quaternion_multiply_normalize_top dut (.*);

  qmn_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] pick_comp(input int mode);
    case (mode)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h2000_0000;
      3: return 32'h0;
      4: return 32'($signed($urandom_range(0, 64)) - 32);
      5: return 32'($signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [255:0] d);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_mode(input logic op, input int mode);
    logic [255:0] d;
    for (int i = 0; i < 8; i++) d[32*i +: 32] = pick_comp(mode);
    send_item(op, d);
  endtask

  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait   <= 0;
    end else if (out_steady) begin
      out_tready <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      w = $urandom_range(0, 16);
      out_wait   <= w;
      out_tready <= (w == 0);
    end else if (out_wait > 0) begin
      out_wait   <= out_wait - 1;
      out_tready <= (out_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("quaternion_multiply_normalize_top test failed");
      $finish;
    end
  end

  initial begin
    logic [255:0] d;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    idle_cycles = 0;
    out_steady = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int m = 0; m < 6; m++) begin
      send_mode(1'b0, m);
      send_mode(1'b1, m);
    end
    send_item(1'b1, {32'h1234_5678, 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'hCAFE_0001, 128'h0});
    send_item(1'b0, {128'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF});
    send_item(1'b0, {32'h0, 32'h0, 32'h0, 32'h2000_0000, 32'h0, 32'h0, 32'h0, 32'h2000_0000});
    send_item(1'b1, {4{32'h2000_0000, 32'hE000_0000}});
    send_item(1'b0, {32'h0000_0001, 96'h0, 32'h0000_0001, 96'h0});
    send_item(1'b0, {8{32'h8000_0000}});
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    out_steady = 1'b1;
    for (int i = 0; i < 40; i++) begin
      in_tvalid <= 1'b1;
      for (int k = 0; k < 8; k++) d[32*k +: 32] = $urandom;
      in_tdata <= d;
      in_tuser <= 1'($urandom_range(0, 1));
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;
    out_steady = 1'b0;
    @(posedge clk);
    for (int i = 0; i < RANDOM_ITEMS; i++)
      send_mode(1'($urandom_range(0, 1)), int'($urandom_range(0, 9)));
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("quaternion_multiply_normalize_top test passed");
    else
      $display("quaternion_multiply_normalize_top test failed");
    $finish;
  end

endmodule
